// ===== rtl/core/heading_velocity_command_top_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef HEADING_VELOCITY_COMMAND_TOP_MACROS_SVH
`define HEADING_VELOCITY_COMMAND_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HVC_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define HVC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define HVC_ASSERT_IMPL(label, clk, rst_n, a, c)
`define HVC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/core/hvc_pkg.sv =====
package hvc_pkg;
    localparam int CordicStepsDefault = 16;
    localparam int TableLen = 24;
    localparam int AngHalfPi = 102944;
    localparam int AngPi = 205887;
    localparam int CordicK = 39797;
    localparam int BearingMax = 25736;

    localparam logic [1:0] REG_MAX_SPEED_X = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED_Y = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;
    localparam logic [1:0] REG_TURN_RATE = 2'd3;

    function automatic logic signed [17:0] atan_entry(input int i);
        logic signed [17:0] r;
        case (i)
            0: r = 18'sd51472;
            1: r = 18'sd30386;
            2: r = 18'sd16055;
            3: r = 18'sd8150;
            4: r = 18'sd4091;
            5: r = 18'sd2047;
            6: r = 18'sd1024;
            7: r = 18'sd512;
            8: r = 18'sd256;
            9: r = 18'sd128;
            10: r = 18'sd64;
            11: r = 18'sd32;
            12: r = 18'sd16;
            13: r = 18'sd8;
            14: r = 18'sd4;
            15: r = 18'sd2;
            16: r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction
endpackage

// ===== rtl/core/heading_velocity_command_top.sv =====
// Pipeline: a vectoring CORDIC for the bearing, then the rotating CORDICs,
// then the multiply and rounding stages.
// Throughput: one item per cycle; busy is always low.
// Reset clears all valid bits and loads the register reset values.
// The result strobe cannot be stalled by the receiver.
`include "heading_velocity_command_top_macros.svh"
module heading_velocity_command_top
    import hvc_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  robot_x,
    input  logic signed [31:0]  robot_y,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [15:0]  robot_heading,
    output logic                done,
    output logic signed [15:0]  vel_x,
    output logic signed [15:0]  vel_y,
    output logic signed [15:0]  vel_turn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int N = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
    localparam int HD = N + 1;

    logic [15:0] max_speed_x_reg;
    logic [15:0] max_speed_y_reg;
    logic [15:0] gain_reg;
    logic [15:0] turn_rate_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_x_reg <= 16'd256;
            max_speed_y_reg <= 16'd256;
            gain_reg <= 16'd2048;
            turn_rate_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_SPEED_X: max_speed_x_reg <= cfg_data;
                REG_MAX_SPEED_Y: max_speed_y_reg <= cfg_data;
                REG_GAIN: gain_reg <= cfg_data;
                REG_TURN_RATE: turn_rate_reg <= cfg_data;
                default: turn_rate_reg <= turn_rate_reg;
            endcase
        end
    end

    // Vectoring CORDIC for the bearing; 33-bit differences grow by about 2 bits.
    logic               vv_reg [0:N];
    logic signed [35:0] vx_reg [0:N];
    logic signed [35:0] vy_reg [0:N];
    logic signed [19:0] vz_reg [0:N];
    logic               vzero_reg [0:N];
    logic signed [15:0] vh_reg [0:N];

    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [35:0] x0;
    logic signed [35:0] y0;
    logic signed [19:0] z0;

    always_comb
    begin
        dx = 36'(target_x) - 36'(robot_x);
        dy = 36'(target_y) - 36'(robot_y);
        x0 = dx;
        y0 = dy;
        z0 = '0;
        if (dx < 0)
        begin
            if (dy >= 0)
            begin
                x0 = dy;
                y0 = -dx;
                z0 = 20'(AngHalfPi);
            end
            else
            begin
                x0 = -dy;
                y0 = dx;
                z0 = -20'(AngHalfPi);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg[0] <= 1'b0;
        end
        else
        begin
            vv_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= x0;
        vy_reg[0] <= y0;
        vz_reg[0] <= z0;
        vzero_reg[0] <= (dx == 0) && (dy == 0);
        vh_reg[0] <= robot_heading;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vv_reg[i+1] <= 1'b0;
            end
            else
            begin
                vv_reg[i+1] <= vv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            vzero_reg[i+1] <= vzero_reg[i];
            vh_reg[i+1] <= vh_reg[i];
            if (vy_reg[i] > 0)
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] + 20'(atan_entry(i));
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] - 20'(atan_entry(i));
            end
        end
    end

    logic signed [19:0] bz;
    logic signed [16:0] br;
    logic signed [15:0] bearing;

    always_comb
    begin
        bz = vzero_reg[N] ? 20'sd0 : vz_reg[N];
        br = 17'((bz + 20'sd4) >>> 3);
        if (br > 17'sd25736)
        begin
            bearing = 16'(BearingMax);
        end
        else if (br < -17'sd25736)
        begin
            bearing = -16'(BearingMax);
        end
        else
        begin
            bearing = 16'(br);
        end
    end

    // The heading is carried along the vectoring pipeline so both rotators start and finish together.
    logic               rb_valid;
    logic signed [17:0] cb;
    logic signed [17:0] sb;
    logic               rh_valid;
    logic signed [17:0] ch;
    logic signed [17:0] sh;

    hvc_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_b
    (
        .clk(clk), .rst_n(rst_n), .in_valid(vv_reg[N]), .in_ang(bearing),
        .out_valid(rb_valid), .out_cos(cb), .out_sin(sb)
    );

    hvc_rot #(.CORDIC_STEPS(CORDIC_STEPS)) u_rot_h
    (
        .clk(clk), .rst_n(rst_n), .in_valid(vv_reg[N]), .in_ang(vh_reg[N]),
        .out_valid(rh_valid), .out_cos(ch), .out_sin(sh)
    );

    // Stage 1: max * gain.
    logic               p1_valid_reg;
    logic [31:0]        kx_reg;
    logic [31:0]        ky_reg;
    logic signed [17:0] cb1_reg, sb1_reg, ch1_reg, sh1_reg;
    // Stage 2: (max*gain) * cos for x and * sin for y, 50 bits, each as two partial products.
    logic               p2_valid_reg;
    logic signed [49:0] mxl_reg, mxh_reg, myl_reg, myh_reg;
    logic signed [17:0] ch2_reg, sh2_reg;
    // Stage 3: sum and round.
    logic               p3_valid_reg;
    logic signed [30:0] vgx_reg, vgy_reg;
    logic signed [17:0] ch3_reg, sh3_reg;
    // Stage 4: four products, each split in two halves.
    logic               p4_valid_reg;
    logic signed [48:0] a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;
    logic signed [48:0] c_lo_reg, c_hi_reg, d_lo_reg, d_hi_reg;
    // Stage 5: combine.
    logic               p5_valid_reg;
    logic signed [50:0] sx_reg, sy_reg;
    // Stage 6: round and saturate.
    logic               done_reg;
    logic signed [15:0] vel_x_reg, vel_y_reg;

    logic signed [50:0] sx_r;
    logic signed [50:0] sy_r;
    logic signed [49:0] mx;
    logic signed [49:0] my;

    always_comb
    begin
        mx = mxl_reg + (mxh_reg <<< 16);
        my = myl_reg + (myh_reg <<< 16);
        sx_r = (sx_reg + (51'sd1 <<< 23)) >>> 24;
        sy_r = (sy_reg + (51'sd1 <<< 23)) >>> 24;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= rb_valid & rh_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            done_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg <= 32'(max_speed_x_reg) * 32'(gain_reg);
        ky_reg <= 32'(max_speed_y_reg) * 32'(gain_reg);
        cb1_reg <= cb;
        sb1_reg <= sb;
        ch1_reg <= ch;
        sh1_reg <= sh;

        mxl_reg <= $signed({34'd0, kx_reg[15:0]}) * 50'(cb1_reg);
        mxh_reg <= $signed({34'd0, kx_reg[31:16]}) * 50'(cb1_reg);
        myl_reg <= $signed({34'd0, ky_reg[15:0]}) * 50'(sb1_reg);
        myh_reg <= $signed({34'd0, ky_reg[31:16]}) * 50'(sb1_reg);
        ch2_reg <= ch1_reg;
        sh2_reg <= sh1_reg;

        vgx_reg <= 31'((mx + (50'sd1 <<< 19)) >>> 20);
        vgy_reg <= 31'((my + (50'sd1 <<< 19)) >>> 20);
        ch3_reg <= ch2_reg;
        sh3_reg <= sh2_reg;

        a_lo_reg <= $signed({34'd0, vgx_reg[14:0]}) * 49'(ch3_reg);
        a_hi_reg <= 49'(vgx_reg >>> 15) * 49'(ch3_reg);
        b_lo_reg <= $signed({34'd0, vgy_reg[14:0]}) * 49'(sh3_reg);
        b_hi_reg <= 49'(vgy_reg >>> 15) * 49'(sh3_reg);
        c_lo_reg <= $signed({34'd0, vgy_reg[14:0]}) * 49'(ch3_reg);
        c_hi_reg <= 49'(vgy_reg >>> 15) * 49'(ch3_reg);
        d_lo_reg <= $signed({34'd0, vgx_reg[14:0]}) * 49'(sh3_reg);
        d_hi_reg <= 49'(vgx_reg >>> 15) * 49'(sh3_reg);

        sx_reg <= 51'(a_lo_reg) + (51'(a_hi_reg) <<< 15)
                + 51'(b_lo_reg) + (51'(b_hi_reg) <<< 15);
        sy_reg <= 51'(c_lo_reg) + (51'(c_hi_reg) <<< 15)
                - 51'(d_lo_reg) - (51'(d_hi_reg) <<< 15);

        if (sx_r > 51'sd32767)
        begin
            vel_x_reg <= 16'sh7fff;
        end
        else if (sx_r < -51'sd32768)
        begin
            vel_x_reg <= 16'sh8000;
        end
        else
        begin
            vel_x_reg <= 16'(sx_r);
        end
        if (sy_r > 51'sd32767)
        begin
            vel_y_reg <= 16'sh7fff;
        end
        else if (sy_r < -51'sd32768)
        begin
            vel_y_reg <= 16'sh8000;
        end
        else
        begin
            vel_y_reg <= 16'(sy_r);
        end
    end

    assign done = done_reg;
    assign vel_x = vel_x_reg;
    assign vel_y = vel_y_reg;
    assign vel_turn = turn_rate_reg;

    `HVC_ASSERT_IMPL(a_rot_aligned, clk, rst_n, rb_valid, rh_valid)
    `HVC_ASSERT_NEXT(a_mul_flow, clk, rst_n, p4_valid_reg, p5_valid_reg)
    `HVC_ASSERT_IMPL(a_never_busy, clk, rst_n, start, !busy)
endmodule

// ===== rtl/core/hvc_rot.sv =====
module hvc_rot
    import hvc_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [15:0]  in_ang,
    output logic                out_valid,
    output logic signed [17:0]  out_cos,
    output logic signed [17:0]  out_sin
);
    localparam int N = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

    logic                valid_reg [0:N];
    logic signed [19:0]  x_reg [0:N];
    logic signed [19:0]  y_reg [0:N];
    logic signed [19:0]  z_reg [0:N];
    logic                flip_reg [0:N];

    logic signed [19:0]  z0;
    logic signed [19:0]  z_next;
    logic                flip_next;

    always_comb
    begin
        z0 = 20'(in_ang) <<< 3;
        flip_next = 1'b0;
        z_next = z0;
        if (z0 > 20'sd102944)
        begin
            z_next = z0 - 20'(AngPi);
            flip_next = 1'b1;
        end
        else if (z0 < -20'sd102944)
        begin
            z_next = z0 + 20'(AngPi);
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= 20'(CordicK);
        y_reg[0] <= '0;
        z_reg[0] <= z_next;
        flip_reg[0] <= flip_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - 20'(atan_entry(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + 20'(atan_entry(i));
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_cos = flip_reg[N] ? 18'(-x_reg[N]) : 18'(x_reg[N]);
    assign out_sin = flip_reg[N] ? 18'(-y_reg[N]) : 18'(y_reg[N]);
endmodule

// ===== tb/tb_heading_velocity_command_top.sv =====
`timescale 1ns / 100ps
module tb_heading_velocity_command_top;
    import hvc_pkg::*;

    localparam int STEPS = (CordicStepsDefault > TableLen) ? TableLen : CordicStepsDefault;
    localparam int DRAIN_CYCLES = 2 * (STEPS + 1) + 6 + 10;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] turn;
    } velocity_cmd_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] robot_heading;
    logic done;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_turn;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    logic [15:0] speed_x_q;
    logic [15:0] speed_y_q;
    logic [15:0] gain_q;
    logic [15:0] turn_q;

    velocity_cmd_t pending_cmds[$];
    longint arctan_lut[24];
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_len;

    heading_velocity_command_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .robot_x(robot_x),
        .robot_y(robot_y),
        .target_x(target_x),
        .target_y(target_y),
        .robot_heading(robot_heading),
        .done(done),
        .vel_x(vel_x),
        .vel_y(vel_y),
        .vel_turn(vel_turn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint bearing_of(input longint dy, input longint dx);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = AngHalfPi;
            end
            else
            begin
                x = -y;
                y = t;
                z = -AngHalfPi;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_lut[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_lut[i];
            end
        end
        return z;
    endfunction

    task automatic unit_vector(input longint ang13, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit flip;
        z = ang13 * 8;
        x = CordicK;
        y = 0;
        flip = 1'b0;
        if (z > AngHalfPi)
        begin
            z = z - AngPi;
            flip = 1'b1;
        end
        else if (z < -AngHalfPi)
        begin
            z = z + AngPi;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_lut[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_lut[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic predict_command(input logic signed [31:0] rx, input logic signed [31:0] ry,
                                   input logic signed [31:0] tx, input logic signed [31:0] ty,
                                   input logic signed [15:0] hd);
        longint brg;
        longint cb;
        longint sb;
        longint ch;
        longint sh;
        longint vgx;
        longint vgy;
        velocity_cmd_t cmd;
        brg = round_shr(bearing_of(longint'(ty) - longint'(ry), longint'(tx) - longint'(rx)), 3);
        if (brg > BearingMax)
            brg = BearingMax;
        if (brg < -BearingMax)
            brg = -BearingMax;
        unit_vector(brg, cb, sb);
        unit_vector(longint'(hd), ch, sh);
        vgx = round_shr(longint'(speed_x_q) * longint'(gain_q) * cb, 20);
        vgy = round_shr(longint'(speed_y_q) * longint'(gain_q) * sb, 20);
        cmd.vx = clamp16(round_shr(vgx * ch + vgy * sh, 24));
        cmd.vy = clamp16(round_shr(vgy * ch - vgx * sh, 24));
        cmd.turn = turn_q;
        pending_cmds = {pending_cmds, cmd};
    endtask

    task automatic send_pose(input logic signed [31:0] rx, input logic signed [31:0] ry,
                             input logic signed [31:0] tx, input logic signed [31:0] ty,
                             input logic signed [15:0] hd);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0)
            begin
                start <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        robot_x <= rx;
        robot_y <= ry;
        target_x <= tx;
        target_y <= ty;
        robot_heading <= hd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_command(rx, ry, tx, ty, hd);
    endtask

    task automatic drain;
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_cmds.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAX_SPEED_X: speed_x_q = val;
            REG_MAX_SPEED_Y: speed_y_q = val;
            REG_GAIN: gain_q = val;
            REG_TURN_RATE: turn_q = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] g, input logic [15:0] tr);
        drain();
        write_reg(REG_MAX_SPEED_X, sx);
        write_reg(REG_MAX_SPEED_Y, sy);
        write_reg(REG_GAIN, g);
        write_reg(REG_TURN_RATE, tr);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_pose;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [15:0] hd;
        rx = $urandom;
        ry = $urandom;
        case ($urandom_range(0, 3))
            0:
            begin
                tx = $urandom;
                ty = $urandom;
            end
            1:
            begin
                tx = rx + $signed($urandom_range(0, 2000000)) - 1000000;
                ty = ry + $signed($urandom_range(0, 2000000)) - 1000000;
            end
            2:
            begin
                tx = rx + $signed($urandom_range(0, 8)) - 4;
                ty = ry + $signed($urandom_range(0, 8)) - 4;
            end
            default:
            begin
                tx = ($urandom_range(0, 1) == 1) ? rx : 32'($urandom);
                ty = ($urandom_range(0, 1) == 1) ? ry : 32'($urandom);
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            hd = 16'($urandom);
        else
            hd = 16'($signed($urandom_range(0, 2 * BearingMax)) - BearingMax);
        send_pose(rx, ry, tx, ty, hd);
    endtask

    task automatic test_reset_values;
        send_pose(0, 0, 32'sh10000, 0, 0);
        send_pose(0, 0, 0, 32'sh10000, 0);
        send_pose(0, 0, 0, 0, 0);
        send_pose(0, 0, -32'sh10000, 0, 0);
        send_pose(0, 0, 0, -32'sh10000, 16'sd12868);
    endtask

    task automatic test_special_cases;
        write_all(16'hffff, 16'hffff, 16'hffff, 16'sh7fff);
        send_pose(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sd0);
        send_pose(32'sh7fffffff, 32'sd5, 32'sh80000000, 32'sd5, 16'sd0);
        send_pose(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'sd25736);
        send_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, -16'sd25736);
        send_pose(0, 32'sh7fffffff, 0, 32'sh80000000, 16'sh7fff);
        send_pose(0, 32'sh80000000, 0, 32'sh7fffffff, 16'sh8000);
        send_pose(1, 0, 0, 0, 16'sh8000);
        send_pose(0, 0, 1, 1, 16'sh7fff);
        write_all(16'h0000, 16'h0000, 16'h0000, 16'sh8000);
        send_pose(0, 0, 100, -100, 16'sd100);
        send_pose(32'hffffffff, 32'hffffffff, 0, 0, -16'sd1);
        write_all(16'h0100, 16'hffff, 16'h1000, 16'h0000);
        send_pose(0, 0, 0, 32'sh20000, 16'sd12868);
        send_pose(0, 0, -32'sh20000, 0, -16'sd12868);
        send_pose(0, 0, 32'sh20000, 32'sh20000, 16'sd6434);
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_all(16'h0100, 16'h0100, 16'h0800, 16'h0040);
                1: write_all(16'hffff, 16'hffff, 16'hffff, 16'sh8000);
                2: write_all(16'h0000, 16'hffff, 16'h0001, 16'sh7fff);
                default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            repeat (300) random_pose();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: vel_x=%0d vel_y=%0d vel_turn=%0d",
                             vel_x, vel_y, vel_turn);
            end
            else
            begin
                velocity_cmd_t exp_cmd;
                exp_cmd = pending_cmds.pop_front();
                if (vel_x !== exp_cmd.vx || vel_y !== exp_cmd.vy || vel_turn !== exp_cmd.turn)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 exp_cmd.vx, exp_cmd.vy, exp_cmd.turn, vel_x, vel_y, vel_turn);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        arctan_lut = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
        speed_x_q = 16'd256;
        speed_y_q = 16'd256;
        gain_q = 16'd2048;
        turn_q = 16'd0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        robot_x <= '0;
        robot_y <= '0;
        target_x <= '0;
        target_y <= '0;
        robot_heading <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_special_cases();
        test_random_traffic();
        drain();
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hvc_pkg.sv
rtl/core/hvc_rot.sv
rtl/core/heading_velocity_command_top.sv
tb/tb_heading_velocity_command_top.sv
